/* sv/esd_pkg.sv */
// ----------------------------------------------------------------------------
// esd_pkg - shared constants, types and tables for the epoch-to-date converter
// Calendar constants, divisor values and the month start table.
// ----------------------------------------------------------------------------
package esd_pkg;

  localparam int unsigned SECS_W  = 31;
  localparam int unsigned YEAR_W  = 11;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned DOY_W   = 9;

  localparam logic [SECS_W-1:0] WINDOW_RESET = 31'd15768000;
  localparam logic [YEAR_W-1:0] EPOCH_YEAR   = 11'd1970;

  // 86400 = 2^7 * 675: the low seven bits of a timestamp pass straight through
  localparam int unsigned DAY_SHIFT   = 7;
  localparam int unsigned DAY_ODD_DIV = 675;
  localparam int unsigned CYCLE_DAYS  = 1461;
  localparam int unsigned SECS_HOUR   = 3600;
  localparam int unsigned SECS_MIN    = 60;

  // first day of each year within a four-year cycle starting in 1970
  localparam logic [10:0] YEAR1_START = 11'd365;
  localparam logic [10:0] YEAR2_START = 11'd730;
  localparam logic [10:0] YEAR3_START = 11'd1096;
  localparam logic [1:0]  LEAP_SLOT   = 2'd2;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

  localparam logic [DOY_W-1:0] MONTH_START [12] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic              show_year;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
  } esd_time_t;

  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    base = MONTH_START[m];
    if (leap && (m > MONTH_FEB)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

/* sv/esd_cdiv.sv */
// ----------------------------------------------------------------------------
// esd_cdiv - pipelined divide by a constant
// Reciprocal multiply, remainder back-multiply, one correction step.
// Three register stages; a side word travels along with each item.
// ----------------------------------------------------------------------------
module esd_cdiv #(
  parameter int unsigned XW  = 24,
  parameter int unsigned DIV = 675,
  parameter int unsigned QW  = 15,
  parameter int unsigned RW  = 10,
  parameter int unsigned SW  = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          valid_i,
  input  logic [XW-1:0] x_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] q_o,
  output logic [RW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  // floor(2^XW / DIV): estimate is the true quotient or one less
  localparam logic [XW-1:0] RECIP   = XW'((64'd1 << XW) / DIV);
  localparam logic [XW-1:0] DIVISOR = XW'(DIV);
  localparam logic [RW:0]   DIV_R   = (RW+1)'(DIV);

  logic            va_r;
  logic [XW-1:0]   x_a_r;
  logic [2*XW-1:0] prod_a_r;
  logic [SW-1:0]   side_a_r;

  logic            vb_r;
  logic [QW-1:0]   q0_b_r, q0_b_nxt;
  logic [RW:0]     r0_b_r, r0_b_nxt;
  logic [SW-1:0]   side_b_r;

  logic            vc_r;
  logic [QW-1:0]   q_c_r, q_c_nxt;
  logic [RW-1:0]   r_c_r, r_c_nxt;
  logic [SW-1:0]   side_c_r;

  logic [XW-1:0]   q0_full;
  logic [XW-1:0]   r0_full;

  always_comb begin
    q0_full  = prod_a_r[2*XW-1:XW];
    r0_full  = x_a_r - XW'(q0_full * DIVISOR);
    q0_b_nxt = q0_full[QW-1:0];
    r0_b_nxt = r0_full[RW:0];
  end

  always_comb begin
    if (r0_b_r >= DIV_R) begin
      q_c_nxt = q0_b_r + QW'(1);
      r_c_nxt = RW'(r0_b_r - DIV_R);
    end else begin
      q_c_nxt = q0_b_r;
      r_c_nxt = r0_b_r[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= valid_i;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_a_r    <= x_i;
      prod_a_r <= x_i * RECIP;
      side_a_r <= side_i;
      q0_b_r   <= q0_b_nxt;
      r0_b_r   <= r0_b_nxt;
      side_b_r <= side_a_r;
      q_c_r    <= q_c_nxt;
      r_c_r    <= r_c_nxt;
      side_c_r <= side_b_r;
    end
  end

  assign valid_o = vc_r;
  assign q_o     = q_c_r;
  assign rem_o   = r_c_r;
  assign side_o  = side_c_r;

  // estimate must be within one divisor of the answer
  a_est_close: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r |-> (r0_b_r < 2 * DIV))
    else $error("esd_cdiv: quotient estimate off by more than one");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r |-> (r_c_r < DIV))
    else $error("esd_cdiv: remainder out of range");

endmodule

/* sv/esd_cal.sv */
// ----------------------------------------------------------------------------
// esd_cal - calendar split of a day within a four-year cycle
// Stage one picks the year and day of year, stage two the month and day.
// ----------------------------------------------------------------------------
module esd_cal (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           valid_i,
  input  logic [4:0]                     cycle_i,
  input  logic [10:0]                    cday_i,
  input  esd_pkg::esd_time_t             tm_i,
  output logic                           valid_o,
  output logic [esd_pkg::YEAR_W-1:0]     year_o,
  output logic [esd_pkg::MONTH_W-1:0]    month_o,
  output logic [esd_pkg::DAY_W-1:0]      day_o,
  output esd_pkg::esd_time_t             tm_o
);

  logic                            vy_r;
  logic [esd_pkg::YEAR_W-1:0]      year_y_r, year_y_nxt;
  logic [esd_pkg::DOY_W-1:0]       doy_y_r, doy_y_nxt;
  logic                            leap_y_r, leap_y_nxt;
  esd_pkg::esd_time_t              tm_y_r;

  logic                            vm_r;
  logic [esd_pkg::YEAR_W-1:0]      year_m_r;
  logic [esd_pkg::MONTH_W-1:0]     month_m_r, month_m_nxt;
  logic [esd_pkg::DAY_W-1:0]       day_m_r, day_m_nxt;
  esd_pkg::esd_time_t              tm_m_r;

  logic [1:0]                      yic;
  logic [10:0]                     ybase;
  logic [esd_pkg::DOY_W-1:0]       mbase;
  logic [esd_pkg::DOY_W-1:0]       mstart;

  always_comb begin
    if (cday_i >= esd_pkg::YEAR3_START) begin
      yic   = 2'd3;
      ybase = esd_pkg::YEAR3_START;
    end else if (cday_i >= esd_pkg::YEAR2_START) begin
      yic   = 2'd2;
      ybase = esd_pkg::YEAR2_START;
    end else if (cday_i >= esd_pkg::YEAR1_START) begin
      yic   = 2'd1;
      ybase = esd_pkg::YEAR1_START;
    end else begin
      yic   = 2'd0;
      ybase = 11'd0;
    end
    doy_y_nxt  = esd_pkg::DOY_W'(cday_i - ybase);
    leap_y_nxt = (yic == esd_pkg::LEAP_SLOT);
    // four years per cycle: 4*cycle + slot is just the concatenation
    year_y_nxt = esd_pkg::EPOCH_YEAR + esd_pkg::YEAR_W'({cycle_i, yic});
  end

  always_comb begin
    month_m_nxt = esd_pkg::MONTH_JAN;
    mbase       = '0;
    mstart      = '0;
    for (int m = 1; m < 12; m++) begin
      mstart = esd_pkg::month_start(esd_pkg::MONTH_W'(m), leap_y_r);
      if (doy_y_r >= mstart) begin
        month_m_nxt = esd_pkg::MONTH_W'(m);
        mbase       = mstart;
      end
    end
    day_m_nxt = esd_pkg::DAY_W'(doy_y_r - mbase + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vy_r <= 1'b0;
      vm_r <= 1'b0;
    end else if (en) begin
      vy_r <= valid_i;
      vm_r <= vy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      year_y_r  <= year_y_nxt;
      doy_y_r   <= doy_y_nxt;
      leap_y_r  <= leap_y_nxt;
      tm_y_r    <= tm_i;
      year_m_r  <= year_y_r;
      month_m_r <= month_m_nxt;
      day_m_r   <= day_m_nxt;
      tm_m_r    <= tm_y_r;
    end
  end

  assign valid_o = vm_r;
  assign year_o  = year_m_r;
  assign month_o = month_m_r;
  assign day_o   = day_m_r;
  assign tm_o    = tm_m_r;

  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    (vm_r && (month_m_r == esd_pkg::MONTH_FEB) && (year_m_r[1:0] != 2'b00))
      |-> (day_m_r <= 5'd28))
    else $error("esd_cal: day 29 in a common-year February");

endmodule

/* sv/epoch_seconds_to_date_top.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_date_top - seconds since 1970 to calendar date and time
// Splits a timestamp into year, month, day, hour and minute, and flags
// timestamps at least as old as the configured window.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_     | in  | tdata: stamp_seconds[30:0], now_seconds[61:31]
//  out_    | out | tdata: year, month_index, day_of_month, hour, minute;
//          |     | tuser: show_year
//  cfg_    | in  | wdata: recent_window
//
//  One transfer per cycle in and out while the output is not stalled;
//  four constant dividers of three stages each, then two calendar stages.
//  Reset clears all valid bits and loads the default window.
//  Every stage holds while a result sits in the output register untaken;
//  nothing is dropped or repeated across a stall.
// ----------------------------------------------------------------------------
module epoch_seconds_to_date_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // stamp_seconds[30:0], now_seconds[61:31]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // year[10:0], month_index[14:11],
                                  // day_of_month[19:15], hour[24:20], minute[30:25]
  output logic        out_tuser,  // show_year[0]
  input  logic        cfg_wen,
  input  logic [30:0] cfg_wdata   // recent_window
);

  localparam int unsigned SW = esd_pkg::SECS_W;

  logic [SW-1:0]  window_r;
  logic           adv;

  logic [SW-1:0]  stamp;
  logic [SW-1:0]  now;
  logic [31:0]    age;
  logic           show;

  logic           v1;
  logic [14:0]    days1;
  logic [9:0]     rem1;
  logic [7:0]     side1;
  logic [16:0]    sod1;

  logic           v2;
  logic [4:0]     cyc2;
  logic [10:0]    cday2;
  logic [17:0]    side2;

  logic           v3;
  logic [4:0]     hour3;
  logic [11:0]    rem3;
  logic [16:0]    side3;

  logic           v4;
  logic [5:0]     min4;
  logic [21:0]    side4;

  esd_pkg::esd_time_t tm4;
  esd_pkg::esd_time_t tm_out;

  logic [esd_pkg::YEAR_W-1:0]  year_out;
  logic [esd_pkg::MONTH_W-1:0] month_out;
  logic [esd_pkg::DAY_W-1:0]   day_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= esd_pkg::WINDOW_RESET;
    end else if (cfg_wen) begin
      window_r <= cfg_wdata;
    end
  end

  // whole pipeline advances unless the output holds an untaken result
  assign adv       = out_tready || !out_tvalid;
  assign in_tready = adv;

  assign stamp = in_tdata[30:0];
  assign now   = in_tdata[61:31];
  assign age   = {1'b0, now} - {1'b0, stamp};
  assign show  = ($signed(age) >= $signed({1'b0, window_r}));

  // days since epoch: (t >> 7) / 675
  esd_cdiv #(
    .XW (SW - esd_pkg::DAY_SHIFT),
    .DIV(esd_pkg::DAY_ODD_DIV),
    .QW (15),
    .RW (10),
    .SW (8)
  ) u_div_day (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .valid_i(in_tvalid && in_tready),
    .x_i    (stamp[SW-1:esd_pkg::DAY_SHIFT]),
    .side_i ({show, stamp[esd_pkg::DAY_SHIFT-1:0]}),
    .valid_o(v1),
    .q_o    (days1),
    .rem_o  (rem1),
    .side_o (side1)
  );

  assign sod1 = {rem1, side1[6:0]};

  // four-year cycles
  esd_cdiv #(
    .XW (15),
    .DIV(esd_pkg::CYCLE_DAYS),
    .QW (5),
    .RW (11),
    .SW (18)
  ) u_div_cycle (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .valid_i(v1),
    .x_i    (days1),
    .side_i ({side1[7], sod1}),
    .valid_o(v2),
    .q_o    (cyc2),
    .rem_o  (cday2),
    .side_o (side2)
  );

  esd_cdiv #(
    .XW (17),
    .DIV(esd_pkg::SECS_HOUR),
    .QW (5),
    .RW (12),
    .SW (17)
  ) u_div_hour (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .valid_i(v2),
    .x_i    (side2[16:0]),
    .side_i ({side2[17], cyc2, cday2}),
    .valid_o(v3),
    .q_o    (hour3),
    .rem_o  (rem3),
    .side_o (side3)
  );

  // remainder here is the seconds, which are dropped
  esd_cdiv #(
    .XW (12),
    .DIV(esd_pkg::SECS_MIN),
    .QW (6),
    .RW (6),
    .SW (22)
  ) u_div_min (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .valid_i(v3),
    .x_i    (rem3),
    .side_i ({side3, hour3}),
    .valid_o(v4),
    .q_o    (min4),
    .rem_o  (),
    .side_o (side4)
  );

  always_comb begin
    tm4.show_year = side4[21];
    tm4.hour      = side4[4:0];
    tm4.minute    = min4;
  end

  esd_cal u_cal (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .valid_i(v4),
    .cycle_i(side4[20:16]),
    .cday_i (side4[15:5]),
    .tm_i   (tm4),
    .valid_o(out_tvalid),
    .year_o (year_out),
    .month_o(month_out),
    .day_o  (day_out),
    .tm_o   (tm_out)
  );

  assign out_tdata = {1'b0, tm_out.minute, tm_out.hour, day_out, month_out, year_out};
  assign out_tuser = tm_out.show_year;

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((month_out <= esd_pkg::MONTH_DEC) && (day_out != 5'd0)))
    else $error("top: month or day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((tm_out.hour <= 5'd23) && (tm_out.minute <= 6'd59)))
    else $error("top: hour or minute out of range");

  a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((year_out >= 11'd1970) && (year_out <= 11'd2038)))
    else $error("top: year out of range");

endmodule

/* tb/epoch_seconds_to_date_top_tb.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_date_top_tb - self-checking bench for the epoch-to-date block
// A directed table of timestamps is followed by random timestamp/now pairs under
// several age windows, with random stalls on both streams. Every output transfer
// is checked field by field against typed rows' values or a calendar predictor.
// ----------------------------------------------------------------------------
module epoch_seconds_to_date_top_tb;

  typedef logic [esd_pkg::SECS_W-1:0] secs_t;

  localparam secs_t             SECS_MAX    = 31'h7FFF_FFFF;
  localparam int unsigned       CYCLE_LIMIT = 300000;
  localparam int unsigned       DRAIN_WAIT  = 30;
  localparam int unsigned       LONG_HOLD   = 200;
  localparam int unsigned       DAY_SECS    = 86400;
  localparam int unsigned       MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                     31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [esd_pkg::YEAR_W-1:0]  year;
    logic [esd_pkg::MONTH_W-1:0] month;
    logic [esd_pkg::DAY_W-1:0]   day;
    logic [esd_pkg::HOUR_W-1:0]  hour;
    logic [esd_pkg::MIN_W-1:0]   minute;
    logic                        show_year;
  } date_rec_t;

  typedef struct {
    secs_t     stamp;
    secs_t     now;
    bit        typed;
    date_rec_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_wen;
  logic [30:0] cfg_wdata;

  date_rec_t         pending_dates [$];
  stim_row_t         date_table [$];
  secs_t             window_model = esd_pkg::WINDOW_RESET;
  int unsigned       error_count  = 0;
  int unsigned       cycle_count  = 0;
  bit                quiet        = 1'b0;
  bit                hold_pending = 1'b0;

  epoch_seconds_to_date_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Calendar split with the plain divisible-by-four leap rule.
  function automatic date_rec_t convert_stamp(input secs_t stamp,
                                              input secs_t now,
                                              input secs_t win);
    date_rec_t   r;
    int unsigned t, yr, len, day, mo, mlen, hr, mn;
    bit          leap;
    longint      age;
    t   = stamp;
    yr  = esd_pkg::EPOCH_YEAR;
    len = (yr % 4 == 0) ? 366 * DAY_SECS : 365 * DAY_SECS;
    while (t >= len) begin
      t   = t - len;
      yr  = yr + 1;
      len = (yr % 4 == 0) ? 366 * DAY_SECS : 365 * DAY_SECS;
    end
    day  = t / DAY_SECS;
    t    = t - day * DAY_SECS;
    hr   = t / 3600;
    t    = t - hr * 3600;
    mn   = t / 60;
    leap = (yr % 4 == 0);
    mo   = esd_pkg::MONTH_JAN;
    while (mo < esd_pkg::MONTH_DEC) begin
      mlen = (mo == esd_pkg::MONTH_FEB) ? (leap ? 29 : 28) : MONTH_DAYS[mo];
      if (day < mlen) break;
      day = day - mlen;
      mo  = mo + 1;
    end
    day         = day + 1;
    age         = longint'(now) - longint'(stamp);
    r.year      = yr[esd_pkg::YEAR_W-1:0];
    r.month     = mo[esd_pkg::MONTH_W-1:0];
    r.day       = day[esd_pkg::DAY_W-1:0];
    r.hour      = hr[esd_pkg::HOUR_W-1:0];
    r.minute    = mn[esd_pkg::MIN_W-1:0];
    r.show_year = (age >= longint'(win));
    return r;
  endfunction

  task automatic add_row(input secs_t stamp, input secs_t now,
                         input bit typed, input int unsigned yr, input int unsigned mo,
                         input int unsigned dy, input int unsigned hr,
                         input int unsigned mn, input bit sy);
    stim_row_t row;
    row.stamp            = stamp;
    row.now              = now;
    row.typed            = typed;
    row.want.year        = yr[esd_pkg::YEAR_W-1:0];
    row.want.month       = mo[esd_pkg::MONTH_W-1:0];
    row.want.day         = dy[esd_pkg::DAY_W-1:0];
    row.want.hour        = hr[esd_pkg::HOUR_W-1:0];
    row.want.minute      = mn[esd_pkg::MIN_W-1:0];
    row.want.show_year   = sy;
    date_table.push_back(row);
  endtask

  task automatic send_stamp(input secs_t stamp, input secs_t now,
                            input bit typed, input date_rec_t want);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, now, stamp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_dates.push_back(typed ? want : convert_stamp(stamp, now, window_model));
  endtask

  // Only while idle: all results back, then a pipeline's worth of slack.
  task automatic write_window(input secs_t value);
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    window_model = value;
  endtask

  // Receiver: random back-pressure, plus one long hold on request.
  initial begin : rx_drive
    int unsigned n;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_tready <= 1'b0;
        for (n = 0; n < LONG_HOLD; n++) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    date_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected output transfer: tdata=%h tuser=%b", out_tdata, out_tuser);
        error_count++;
      end else begin
        want = pending_dates.pop_front();
        if (out_tdata[10:0] !== want.year) begin
          $error("year: expected %0d, got %0d", want.year, out_tdata[10:0]);
          error_count++;
        end
        if (out_tdata[14:11] !== want.month) begin
          $error("month_index: expected %0d, got %0d", want.month, out_tdata[14:11]);
          error_count++;
        end
        if (out_tdata[19:15] !== want.day) begin
          $error("day_of_month: expected %0d, got %0d", want.day, out_tdata[19:15]);
          error_count++;
        end
        if (out_tdata[24:20] !== want.hour) begin
          $error("hour: expected %0d, got %0d", want.hour, out_tdata[24:20]);
          error_count++;
        end
        if (out_tdata[30:25] !== want.minute) begin
          $error("minute: expected %0d, got %0d", want.minute, out_tdata[30:25]);
          error_count++;
        end
        if (out_tuser !== want.show_year) begin
          $error("show_year: expected %0d, got %0d", want.show_year, out_tuser);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : main_seq
    int unsigned k, ph, mode;
    secs_t       stamp, now;
    longint      sum;
    date_rec_t   none;
    secs_t       windows [5];
    none      = '0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wen   = 1'b0;
    cfg_wdata = '0;

    // typed rows use the reset window
    add_row(31'd0,        31'd0,        1'b1, 1970, 0,  1,  0,  0,  1'b0);
    add_row(SECS_MAX,     31'd0,        1'b1, 2038, 0,  19, 3,  14, 1'b0);
    add_row(31'd0,        SECS_MAX,     1'b1, 1970, 0,  1,  0,  0,  1'b1);
    add_row(31'd0,        31'd15768000, 1'b1, 1970, 0,  1,  0,  0,  1'b1);
    add_row(31'd0,        31'd15767999, 1'b1, 1970, 0,  1,  0,  0,  1'b0);
    add_row(31'd31535999, 31'd31535999, 1'b1, 1970, 11, 31, 23, 59, 1'b0);
    add_row(31'd31536000, 31'd0,        1'b1, 1971, 0,  1,  0,  0,  1'b0);
    add_row(SECS_MAX,     SECS_MAX,     1'b1, 2038, 0,  19, 3,  14, 1'b0);
    // leap days, year ends, stamp newer than now, bit patterns
    add_row(31'd68169600,  31'd83937600,  1'b0, 0, 0, 0, 0, 0, 1'b0);
    add_row(31'd68169599,  31'd68169599,  1'b0, 0, 0, 0, 0, 0, 1'b0);
    add_row(31'd68256000,  31'd84024001,  1'b0, 0, 0, 0, 0, 0, 1'b0);
    add_row(31'd94694399,  31'd94694400,  1'b0, 0, 0, 0, 0, 0, 1'b0);
    add_row(31'd946684800, 31'd946684799, 1'b0, 0, 0, 0, 0, 0, 1'b0);
    add_row(31'd951782400, 31'd967550400, 1'b0, 0, 0, 0, 0, 0, 1'b0);
    add_row(31'h5555_5555, 31'h2AAA_AAAA, 1'b0, 0, 0, 0, 0, 0, 1'b0);
    add_row(31'h2AAA_AAAA, 31'h5555_5555, 1'b0, 0, 0, 0, 0, 0, 1'b0);
    add_row(31'd1234567890, 31'd1250335890, 1'b0, 0, 0, 0, 0, 0, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (date_table[i])
      send_stamp(date_table[i].stamp, date_table[i].now, date_table[i].typed,
                 date_table[i].want);
    in_tvalid <= 1'b0;

    windows[0] = 31'd0;
    windows[1] = SECS_MAX;
    windows[2] = secs_t'($urandom & SECS_MAX);
    windows[3] = secs_t'($urandom_range(0, 100000));
    windows[4] = esd_pkg::WINDOW_RESET;

    for (ph = 0; ph < 5; ph++) begin
      write_window(windows[ph]);
      if (ph == 1) hold_pending = 1'b1;
      if (ph == 4) quiet = 1'b1;
      for (k = 0; k < 100; k++) begin
        mode = $urandom_range(0, 9);
        if (mode < 3) begin
          stamp = secs_t'($urandom & SECS_MAX);
          now   = secs_t'($urandom & SECS_MAX);
        end else if (mode < 6) begin
          // age close to the window, equality included
          stamp = secs_t'($urandom_range(0, SECS_MAX - window_model));
          sum   = longint'(stamp) + longint'(window_model)
                  + longint'($urandom_range(0, 4)) - 2;
          if (sum < 0) now = 31'd0;
          else if (sum > longint'(SECS_MAX)) now = SECS_MAX;
          else now = secs_t'(sum);
        end else if (mode < 8) begin
          // just either side of midnight on a random day
          sum = longint'($urandom_range(0, 24855)) * longint'(DAY_SECS);
          if ($urandom_range(0, 1) == 0) sum = sum + longint'($urandom_range(0, 119));
          else sum = sum - longint'($urandom_range(1, 120));
          if (sum < 0) sum = 0;
          if (sum > longint'(SECS_MAX)) sum = longint'(SECS_MAX);
          stamp = secs_t'(sum);
          now   = ($urandom_range(0, 1) == 0) ? stamp : secs_t'($urandom & SECS_MAX);
        end else if (mode == 8) begin
          // stamp newer than now
          stamp = secs_t'($urandom_range(1, SECS_MAX));
          now   = secs_t'($urandom_range(0, stamp - 1));
        end else begin
          stamp = ($urandom_range(0, 1) == 0) ? 31'd0 : SECS_MAX;
          now   = ($urandom_range(0, 1) == 0) ? 31'd0 : SECS_MAX;
        end
        send_stamp(stamp, now, 1'b0, none);
      end
      in_tvalid <= 1'b0;
    end

    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/esd_pkg.sv
sv/esd_cdiv.sv
sv/esd_cal.sv
sv/epoch_seconds_to_date_top.sv
tb/epoch_seconds_to_date_top_tb.sv
